@@ sv/rts_pkg.sv @@
// Package for the repeating timer scheduler: sizes, opcodes, status codes.
// No dependencies.
package rts_pkg;
    localparam int MAX_TIMERS         = 64;
    localparam int MAX_FIRES_PER_TICK = 16;
    localparam int SLOT_W             = $clog2(MAX_TIMERS);
    localparam int FIRE_W             = $clog2(MAX_FIRES_PER_TICK + 1);

    localparam logic [1:0] OP_CREATE = 2'd0;
    localparam logic [1:0] OP_KILL   = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    localparam logic [1:0] ST_CREATED = 2'd0;
    localparam logic [1:0] ST_FIRED   = 2'd1;
    localparam logic [1:0] ST_INVALID = 2'd2;
    localparam logic [1:0] ST_FULL    = 2'd3;

    // one timer table entry
    typedef struct packed {
        logic [63:0] trig;
        logic [41:0] ival;
        logic [31:0] reps;
        logic [31:0] hdl;
    } t_entry;
endpackage

@@ sv/rts_table.sv @@
// Timer table memory: one synchronous-read port, one write port.
// Depends on rts_pkg.
module rts_table
    import rts_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [SLOT_W-1:0] i_waddr,
    input  t_entry            i_wdata,
    input  logic [SLOT_W-1:0] i_raddr,
    output t_entry            o_rdata
);
    t_entry mem [MAX_TIMERS];

    // registered read, write port separate
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

@@ sv/repeating_timer_scheduler.sv @@
// Repeating timer scheduler: timer table in one memory, sequencer scans it.
// Create: busy through S_CRMUL and S_CREATE after the accept edge, result strobed in the cycle after.
// Kill: busy through a scan of all slots (one read per slot), none for handle 0; no result.
// Tick: each pass scans all slots (one read per slot), then S_TRD and S_TUPD;
// one pass per firing (up to MAX_FIRES_PER_TICK) and per killed free, then an
// empty pass unless the bound is hit, then S_DONE. Reset clears slot valid
// flags and next handle; busy is low after reset. Receiver cannot stall.
module repeating_timer_scheduler
    import rts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [63:0] i_now_us,
    input  logic signed [31:0] i_delay_ms,
    input  logic signed [31:0] i_interval_ms,
    input  logic signed [31:0] i_repeat_count,
    input  logic [31:0] i_timer_handle,
    output logic        o_strobe,
    output logic [1:0]  o_status,
    output logic [31:0] o_handle,
    output logic        o_last
);
    typedef enum logic [2:0] {S_IDLE, S_CRMUL, S_CREATE, S_KSCAN, S_TSCAN,
                              S_TRD, S_TUPD, S_DONE} t_state;

    t_state            r_state;
    logic [MAX_TIMERS-1:0] r_valid;
    logic [31:0]       r_next_handle;
    logic [63:0]       r_now;
    logic signed [31:0] r_delay, r_ival, r_cnt;
    logic [31:0]       r_khdl;
    logic [63:0]       r_dmul;
    logic [41:0]       r_imul;
    logic [SLOT_W:0]   r_scan;    // read address counter
    logic [SLOT_W-1:0] r_rslot;   // slot of data now on read port
    logic              r_rval;
    logic              r_found;
    logic [SLOT_W-1:0] r_best;
    logic [63:0]       r_best_trig;
    logic [FIRE_W-1:0] r_fired;
    logic              r_pend;    // a fire result held back to learn last
    logic [31:0]       r_pend_hdl;

    logic              we;
    logic [SLOT_W-1:0] waddr, raddr;
    t_entry            wdata, rdata;

    rts_table u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // first free slot
    logic              free_ok;
    logic [SLOT_W-1:0] free_slot;
    always_comb begin
        free_ok   = 1'b0;
        free_slot = '0;
        for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_ok   = 1'b1;
                free_slot = SLOT_W'(i);
            end
        end
    end

    logic [64:0] trig_sum;
    logic [63:0] trig_new;
    logic [64:0] resch_sum;
    logic [31:0] hnew;
    logic        bad;
    assign bad      = (r_delay < -32'sd1) || (r_ival < 0) || (r_cnt < -32'sd1);
    assign hnew     = (r_next_handle == 32'hFFFF_FFFF) ? 32'd1 : r_next_handle + 32'd1;
    assign trig_sum = {1'b0, r_now} + {1'b0, r_dmul};
    always_comb begin
        if (r_delay < 0) begin
            trig_new = (r_now >= 64'd1000) ? r_now - 64'd1000 : 64'd0;
        end else begin
            trig_new = trig_sum[64] ? '1 : trig_sum[63:0];
        end
    end
    assign resch_sum = {1'b0, rdata.trig} + {23'd0, rdata.ival};

    // memory port drive
    always_comb begin
        we    = 1'b0;
        waddr = r_rslot;
        wdata = rdata;
        raddr = r_scan[SLOT_W-1:0];
        case (r_state)
            S_CREATE: begin
                we    = !bad && free_ok;
                waddr = free_slot;
                wdata.trig = trig_new;
                wdata.ival = r_imul;
                wdata.reps = r_cnt;
                wdata.hdl  = hnew;
            end
            S_KSCAN: begin
                we = r_rval && r_valid[r_rslot] && (rdata.hdl == r_khdl);
                wdata.reps = '0;
            end
            S_TRD: raddr = r_best;
            S_TUPD: begin
                we = (rdata.reps != 32'd0) && (rdata.reps != 32'd1);
                waddr = r_best;
                wdata.trig = resch_sum[64] ? '1 : resch_sum[63:0];
                if ($signed(rdata.reps) > 32'sd1) begin
                    wdata.reps = rdata.reps - 32'd1;
                end
            end
            default: ;
        endcase
    end

    assign busy = (r_state != S_IDLE);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_valid       <= '0;
            r_next_handle <= '0;
            r_pend        <= 1'b0;
            o_strobe      <= 1'b0;
        end else begin
            o_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_now   <= i_now_us;
                        r_delay <= i_delay_ms;
                        r_ival  <= i_interval_ms;
                        r_cnt   <= i_repeat_count;
                        r_khdl  <= i_timer_handle;
                        r_scan  <= '0;
                        r_rval  <= 1'b0;
                        r_found <= 1'b0;
                        r_fired <= '0;
                        case (i_opcode)
                            OP_CREATE: r_state <= S_CRMUL;
                            OP_KILL:   r_state <= (i_timer_handle == 0) ? S_IDLE : S_KSCAN;
                            OP_TICK:   r_state <= S_TSCAN;
                            default:   r_state <= S_IDLE;
                        endcase
                    end
                end
                S_CRMUL: begin
                    r_dmul  <= 64'(41'(r_delay[30:0]) * 41'd1000);
                    r_imul  <= 42'(r_ival[30:0]) * 42'd1000;
                    r_state <= S_CREATE;
                end
                S_CREATE: begin
                    o_strobe <= 1'b1;
                    o_last   <= 1'b1;
                    if (bad) begin
                        o_status <= ST_INVALID;
                        o_handle <= '0;
                    end else if (!free_ok) begin
                        o_status <= ST_FULL;
                        o_handle <= '0;
                    end else begin
                        o_status      <= ST_CREATED;
                        o_handle      <= hnew;
                        r_next_handle <= hnew;
                        r_valid[free_slot] <= 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                S_KSCAN: begin
                    r_rslot <= r_scan[SLOT_W-1:0];
                    r_rval  <= (r_scan < (SLOT_W+1)'(MAX_TIMERS));
                    r_scan  <= r_scan + 1'b1;
                    if (r_rval && !(r_scan < (SLOT_W+1)'(MAX_TIMERS))) begin
                        r_state <= S_IDLE;
                    end
                end
                S_TSCAN: begin
                    // read slots in order, keep strict-earliest due one
                    r_rslot <= r_scan[SLOT_W-1:0];
                    r_rval  <= (r_scan < (SLOT_W+1)'(MAX_TIMERS));
                    r_scan  <= r_scan + 1'b1;
                    if (r_rval && r_valid[r_rslot] && (rdata.trig <= r_now)
                        && (!r_found || rdata.trig < r_best_trig)) begin
                        r_found     <= 1'b1;
                        r_best      <= r_rslot;
                        r_best_trig <= rdata.trig;
                    end
                    if (r_rval && !(r_scan < (SLOT_W+1)'(MAX_TIMERS))) begin
                        r_state <= S_TRD;
                    end
                end
                S_TRD: begin
                    // read port is addressed with r_best in this cycle
                    r_state <= r_found ? S_TUPD : S_DONE;
                end
                S_TUPD: begin
                    if (rdata.reps == 32'd0 || rdata.reps == 32'd1) begin
                        r_valid[r_best] <= 1'b0;
                    end
                    if (rdata.reps != 32'd0) begin
                        if (r_pend) begin
                            o_strobe <= 1'b1;
                            o_status <= ST_FIRED;
                            o_handle <= r_pend_hdl;
                            o_last   <= 1'b0;
                        end
                        r_pend     <= 1'b1;
                        r_pend_hdl <= rdata.hdl;
                        r_fired    <= r_fired + 1'b1;
                    end
                    r_scan  <= '0;
                    r_found <= 1'b0;
                    if ((rdata.reps != 32'd0) &&
                        (r_fired + 1'b1 == FIRE_W'(MAX_FIRES_PER_TICK))) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_TSCAN;
                    end
                end
                S_DONE: begin
                    if (r_pend) begin
                        o_strobe <= 1'b1;
                        o_status <= ST_FIRED;
                        o_handle <= r_pend_hdl;
                        o_last   <= 1'b1;
                    end
                    r_pend  <= 1'b0;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
